[hw/rtl/md5sh_pkg.sv]
`timescale 1ns / 1ps

package md5sh_pkg;

   // one message byte item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_item_type;

   // one digest word item
   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_item_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   // controls from the sequencer to the round datapath
   typedef struct packed {
      logic       init;
      logic       load;
      logic       step;
      logic       fold;
      logic [5:0] round;
   } core_ctrl_type;

   localparam int BLOCK_BYTES = 64;
   localparam int LEN_OFFSET  = 56;
   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] MD5_IV [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   // per-round additive constants
   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotate amounts, indexed by {round group, round mod 4}
   localparam logic [4:0] MD5_S [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word used by a round
   function automatic logic [3:0] md5_g(input logic [5:0] r);
      logic [3:0] rl;
      logic [3:0] g;
      rl = r[3:0];
      case (r[5:4])
         2'b00:   g = rl;
         2'b01:   g = 4'(rl * 4'd5 + 4'd1);
         2'b10:   g = 4'(rl * 4'd3 + 4'd5);
         default: g = 4'(rl * 4'd7);
      endcase
      return g;
   endfunction

endpackage

[hw/rtl/md5_stream_hasher_unit.sv]
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_item (data_byte, has_byte, last)
// rsp      out        rsp_valid / rsp_ready  rsp_item (digest_word, word_index, last_word)
//
// a byte item is written into the block buffer when taken; every 64th byte starts a
// compression (one read setup, 64 rounds of the shared round unit, one fold)
// padding writes one byte per cycle into the block buffer, then one or two
// compressions follow, then the four digest words go out in order
// req_ready is low from a full block until compression ends, and during padding and output
// synchronous reset returns the chaining words to the initial values

module md5_stream_hasher_unit import md5sh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_item_type  req_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_item_type  rsp_item
);

   state_type state_ff, state_in;
   logic [6:0]  fill_ff, fill_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [5:0]  round_ff, round_in;
   logic        pad_ff, pad_in;
   logic        mark_ff, mark_in;
   logic        extra_ff, extra_in;
   logic        final_ff, final_in;
   logic [1:0]  out_idx_ff, out_idx_in;

   logic        wr_en;
   logic [7:0]  wr_data;
   logic [3:0]  rd_addr;
   logic [31:0] msg_word;
   core_ctrl_type ctrl;
   logic [3:0][31:0] chain_value;

   md5sh_msg_buf u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[5:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (msg_word)
   );

   md5sh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .msg_word    (msg_word),
      .chain_value (chain_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_item.has_byte && fill_ff == 7'(BLOCK_BYTES - 1)) begin
                  state_in = ST_PREP;
               end else if (req_item.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == 7'(BLOCK_BYTES)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (final_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready && out_idx_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and register updates
   always_comb begin
      fill_in    = fill_ff;
      bitlen_in  = bitlen_ff;
      round_in   = round_ff;
      pad_in     = pad_ff;
      mark_in    = mark_ff;
      extra_in   = extra_ff;
      final_in   = final_ff;
      out_idx_in = out_idx_ff;
      wr_en      = 1'b0;
      wr_data    = req_item.data_byte;
      rd_addr    = md5_g(6'd0);
      ctrl       = '{init: 1'b0, load: 1'b0, step: 1'b0, fold: 1'b0, round: round_ff};
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pad_in = req_item.last;
               if (req_item.has_byte) begin
                  wr_en     = 1'b1;
                  fill_in   = fill_ff + 7'd1;
                  bitlen_in = bitlen_ff + 64'd8;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff != 7'(BLOCK_BYTES)) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + 7'd1;
               if (!mark_ff) begin
                  // end-of-message marker
                  wr_data  = PAD_MARK;
                  mark_in  = 1'b1;
                  extra_in = (fill_ff >= 7'(LEN_OFFSET));
               end else if (extra_ff || fill_ff < 7'(LEN_OFFSET)) begin
                  wr_data = 8'd0;
               end else begin
                  // bit length, least significant byte first
                  wr_data = bitlen_ff[8*fill_ff[2:0] +: 8];
                  if (fill_ff == 7'(BLOCK_BYTES - 1)) begin
                     final_in = 1'b1;
                  end
               end
            end
         end
         ST_PREP: begin
            ctrl.load = 1'b1;
            fill_in   = 7'd0;
            extra_in  = 1'b0;
         end
         ST_ROUND: begin
            ctrl.step = 1'b1;
            rd_addr   = md5_g(round_ff + 6'd1);
            round_in  = round_ff + 6'd1;
         end
         ST_FOLD: begin
            ctrl.fold = 1'b1;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 2'd1;
               if (out_idx_ff == 2'd3) begin
                  ctrl.init = 1'b1;
                  bitlen_in = 64'd0;
                  pad_in    = 1'b0;
                  mark_in   = 1'b0;
                  extra_in  = 1'b0;
                  final_in  = 1'b0;
                  fill_in   = 7'd0;
               end
            end
         end
         default: ;
      endcase
   end

   // result payload straight from the chaining words
   always_comb begin
      rsp_item.digest_word = chain_value[out_idx_ff];
      rsp_item.word_index  = out_idx_ff;
      rsp_item.last_word   = (out_idx_ff == 2'd3);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= 7'd0;
         bitlen_ff  <= 64'd0;
         round_ff   <= 6'd0;
         pad_ff     <= 1'b0;
         mark_ff    <= 1'b0;
         extra_ff   <= 1'b0;
         final_ff   <= 1'b0;
         out_idx_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         bitlen_ff  <= bitlen_in;
         round_ff   <= round_in;
         pad_ff     <= pad_in;
         mark_ff    <= mark_in;
         extra_ff   <= extra_in;
         final_ff   <= final_in;
         out_idx_ff <= out_idx_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while digest output is pending");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'(BLOCK_BYTES))
      else $error("block fill count out of range");

   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_ROUND |-> round_ff == 6'd0)
      else $error("round counter left nonzero outside compression");

   a_clean_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_item.last_word |=>
         state_ff == ST_IDLE && fill_ff == 7'd0 && bitlen_ff == 64'd0)
      else $error("state not cleared after final digest word");
`endif

endmodule

[hw/rtl/md5sh_msg_buf.sv]
`timescale 1ns / 1ps

module md5sh_msg_buf import md5sh_pkg::*; (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [5:0]  wr_addr,
   input  logic [7:0]  wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem [16];
   logic [31:0] rd_data_ff;

   // byte-lane write, little-endian within each word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_data;
      end
   end

   // registered word read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/md5sh_core.sv]
`timescale 1ns / 1ps

module md5sh_core import md5sh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  core_ctrl_type      ctrl,
   input  logic [31:0]        msg_word,
   output logic [3:0][31:0]   chain_value
);

   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [3:0][31:0] chain_ff;
   logic [31:0] f_val;
   logic [31:0] sum_val;
   logic [63:0] rot_dbl;
   logic [31:0] new_b;

   // round logic function
   always_comb begin
      case (ctrl.round[5:4])
         2'b00:   f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'b01:   f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'b10:   f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
   end

   // add, rotate, add
   always_comb begin
      sum_val = a_ff + f_val + MD5_K[ctrl.round] + msg_word;
      rot_dbl = {sum_val, sum_val} << MD5_S[{ctrl.round[5:4], ctrl.round[1:0]}];
      new_b   = b_ff + rot_dbl[63:32];
   end

   // working words
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (ctrl.step) begin
         a_ff <= d_ff;
         b_ff <= new_b;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
   end

   // chaining words
   always_ff @(posedge clock) begin
      if (reset || ctrl.init) begin
         for (int i = 0; i < 4; i++) begin
            chain_ff[i] <= MD5_IV[i];
         end
      end else if (ctrl.fold) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
      end
   end

   assign chain_value = chain_ff;

endmodule

[test/md5_digest_checker.sv]
`timescale 1ns / 1ps

module md5_digest_checker import md5sh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  req_item_type  req_item,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  rsp_item_type  rsp_item,
   output int            mismatch_count,
   output int            words_pending
);

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // left rotate per round group and round mod 4
   localparam int ROT_AMT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   localparam logic [31:0] START_H [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [7:0] END_MARK = 8'h80;
   localparam int LEN_POS = 56;

   // predicted hasher state
   logic [31:0]  chain_h [4];
   logic [7:0]   blk_buf [64];
   int           fill_n;
   logic [63:0]  msg_bits;
   rsp_item_type digest_q [$];
   int           errors;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void restart_digest();
      for (int i = 0; i < 4; i++) chain_h[i] = START_H[i];
      for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
      fill_n = 0;
      msg_bits = 64'd0;
   endfunction

   // 64 rounds over the buffered block, folded into the chaining words
   function automatic void compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int g;
      for (int i = 0; i < 16; i++)
         w[i] = {blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         t = a + f + ROUND_CONST[r] + w[g];
         a = d;
         d = c;
         c = b;
         b = b + rotl(t, ROT_AMT[(r / 16) * 4 + r % 4]);
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
   endfunction

   // take one item; on end of message pad, finish and queue the four words
   function automatic void absorb_item(input req_item_type it);
      rsp_item_type word;
      if (it.has_byte) begin
         blk_buf[fill_n] = it.data_byte;
         fill_n++;
         msg_bits += 64'd8;
         if (fill_n == 64) begin
            compress_block();
            fill_n = 0;
         end
      end
      if (!it.last) return;
      blk_buf[fill_n] = END_MARK;
      fill_n++;
      if (fill_n > LEN_POS) begin
         while (fill_n < 64) begin
            blk_buf[fill_n] = 8'h00;
            fill_n++;
         end
         compress_block();
         fill_n = 0;
      end
      while (fill_n < LEN_POS) begin
         blk_buf[fill_n] = 8'h00;
         fill_n++;
      end
      for (int i = 0; i < 8; i++) blk_buf[LEN_POS + i] = msg_bits[8*i +: 8];
      compress_block();
      for (int i = 0; i < 4; i++) begin
         word.digest_word = chain_h[i];
         word.word_index  = 2'(i);
         word.last_word   = (i == 3);
         digest_q = {digest_q, word};
      end
      restart_digest();
   endfunction

   initial begin
      errors = 0;
      restart_digest();
   end

   // compare digest words, then predict from the accepted item
   always @(posedge clock) begin : watch_channels
      rsp_item_type want;
      if (reset) begin
         restart_digest();
         digest_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected digest word %h index %0d last %b",
                           $realtime, rsp_item.digest_word, rsp_item.word_index,
                           rsp_item.last_word);
            end else begin
               want = digest_q.pop_front();
               if (want.digest_word !== rsp_item.digest_word ||
                   want.word_index !== rsp_item.word_index ||
                   want.last_word !== rsp_item.last_word) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                              $realtime, want.digest_word, want.word_index,
                              want.last_word, rsp_item.digest_word,
                              rsp_item.word_index, rsp_item.last_word);
               end
            end
         end
         if (req_valid && req_ready) absorb_item(req_item);
      end
      mismatch_count <= errors;
      words_pending  <= digest_q.size();
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top import md5sh_pkg::*; ();

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SLOW} rx_mode_type;

   localparam int LONG_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;
   int           mismatch_count;
   int           words_pending;

   int           burst_left;
   rx_mode_type  rx_mode;
   int           rx_left;

   md5_stream_hasher_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   md5_digest_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always #5 clock = ~clock;

   function automatic req_item_type mk_item(input logic [7:0] b, input logic hb,
                                            input logic lst);
      req_item_type it;
      it.data_byte = b;
      it.has_byte  = hb;
      it.last      = lst;
      return it;
   endfunction

   // send one item, opening a new burst after a random gap when due
   task automatic send_req(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      burst_left--;
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender until every digest word is back
   task automatic drain_digests();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   // receiver stall pattern, with the mode picked anew at random when its run ends
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         default:   rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   initial begin
      #5_000_000;
      $display("md5_stream_hasher_unit regression: fail");
      $finish;
   end

   initial begin
      int  counted;
      int  len;
      bit  tail_byte;
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      rsp_ready  = 1'b0;
      burst_left = 0;
      rx_mode    = RX_OPEN;
      rx_left    = 0;
      counted    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle, empty message, "abc", single extreme bytes
      send_req(mk_item(8'h00, 1'b0, 1'b0));
      send_req(mk_item(8'h00, 1'b0, 1'b1));
      send_req(mk_item(8'h61, 1'b1, 1'b0));
      send_req(mk_item(8'h62, 1'b1, 1'b0));
      send_req(mk_item(8'h63, 1'b1, 1'b1));
      send_req(mk_item(8'h00, 1'b1, 1'b1));
      send_req(mk_item(8'hff, 1'b1, 1'b1));
      // byte, ignored item, then an empty closing item
      send_req(mk_item(8'h5a, 1'b1, 1'b0));
      send_req(mk_item(8'hff, 1'b0, 1'b0));
      send_req(mk_item(8'ha5, 1'b0, 1'b1));
      drain_digests();

      // random messages, mostly short, some around the padding boundaries
      while (counted < 110) begin
         if ($urandom_range(0, 9) < 2)
            len = LONG_LENS[$urandom_range(0, 9)];
         else
            len = $urandom_range(0, 12);
         // keep the total item count close to the target
         if (len > 130 - counted)
            len = $urandom_range(0, 12);
         tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_req(mk_item(8'($urandom), 1'b0, 1'b0));
            send_req(mk_item(8'($urandom), 1'b1, tail_byte && (i == len - 1)));
            counted++;
         end
         if (!tail_byte) begin
            send_req(mk_item(8'($urandom), 1'b0, 1'b1));
            counted++;
         end
      end

      drain_digests();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0)
         $display("md5_stream_hasher_unit regression: pass");
      else
         $display("md5_stream_hasher_unit regression: fail");
      $finish;
   end

endmodule
